// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden condition");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: sv/pngse_pkg.sv
// ----------------------------------------------------------------------------
// PNG stored-block encoder package
// Shared constants, command and status types, CRC byte update.
// ----------------------------------------------------------------------------
package pngse_pkg;

  localparam int unsigned MAX_W     = 8192;
  localparam int unsigned MAX_H     = 8192;
  localparam int unsigned BLK_LIMIT = 65535;
  localparam int unsigned ADLER_MOD = 65521;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] HDR_LEN0  = 6'd33;
  localparam logic [5:0] BLK_LAST  = 6'd4;
  localparam logic [5:0] TAIL_LAST = 6'd19;

  typedef enum logic [2:0] {
    SRC_HDR,
    SRC_BLK,
    SRC_FILT,
    SRC_PIX,
    SRC_TAIL
  } src_t;

  typedef struct packed {
    logic       take;
    logic       start;
    logic       emit;
    src_t       src;
    logic [5:0] idx;
    logic       last;
    logic       eoi;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic bir_zero;
    logic fill_zero;
    logic rem_one;
    logic out_free;
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/png_stored_block_encoder.sv
// ----------------------------------------------------------------------------
// PNG stored-block encoder
// Streams a complete PNG file (signature, IHDR, stored-deflate IDAT, IEND)
// from raw pixel bytes in raster order.
// ----------------------------------------------------------------------------
//   channel  | signals                                  | direction
//   in       | in_valid, in_stall, pixel_byte           | sink
//   out      | out_valid, out_stall, out_byte, last_of_run, end_of_image | source
//   cfg      | cfg_we, cfg_index, cfg_data              | sink, write only
//
// A pixel byte is taken in idle and passes the decision states before the output bytes it causes.
// The first byte of an image adds the header bytes, the last adds the trailer bytes.
// The controller emits each byte through the single output register.
// Output stall holds the sequencer; input stall is high outside idle.
// Reset is synchronous; geometry registers return to 1 x 1 RGB.
module png_stored_block_encoder import pngse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_image
);

  cmd_t    cmd;
  status_t st;

  pngse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pngse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_byte   (pixel_byte),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

endmodule

// File: sv/pngse_ctrl.sv
// ----------------------------------------------------------------------------
// PNG stored-block encoder controller
// Sequences header, block header, raw and trailer bytes for each transfer.
// ----------------------------------------------------------------------------
module pngse_ctrl import pngse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE, HDR, RDEC, FHDR, FILT, PDEC, PHDR, PIX, TAIL
  } state_t;

  state_t     state;
  logic [5:0] k;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd       = '0;
    cmd.idx   = k;
    cmd.src   = SRC_HDR;
    cmd.take  = (state == IDLE) && in_valid;
    cmd.start = cmd.take && !st.started;
    case (state)
      HDR:  begin cmd.emit = st.out_free; cmd.src = SRC_HDR;  end
      FHDR: begin cmd.emit = st.out_free; cmd.src = SRC_BLK;  end
      PHDR: begin cmd.emit = st.out_free; cmd.src = SRC_BLK;  end
      FILT: begin cmd.emit = st.out_free; cmd.src = SRC_FILT; end
      PIX: begin
        cmd.emit = st.out_free;
        cmd.src  = SRC_PIX;
        cmd.last = !st.rem_one;
      end
      TAIL: begin
        cmd.emit = st.out_free;
        cmd.src  = SRC_TAIL;
        cmd.last = (k == TAIL_LAST);
        cmd.eoi  = (k == TAIL_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      k     <= '0;
    end else begin
      case (state)
        IDLE: if (in_valid) begin
          k     <= '0;
          state <= st.started ? RDEC : HDR;
        end
        HDR: if (st.out_free) begin
          k <= k + 6'd1;
          if (k == HDR_LAST) state <= RDEC;
        end
        RDEC: begin
          k <= '0;
          if (!st.bir_zero)      state <= PDEC;
          else if (st.fill_zero) state <= FHDR;
          else                   state <= FILT;
        end
        FHDR: if (st.out_free) begin
          k <= k + 6'd1;
          if (k == BLK_LAST) state <= FILT;
        end
        FILT: if (st.out_free) state <= PDEC;
        PDEC: begin
          k     <= '0;
          state <= st.fill_zero ? PHDR : PIX;
        end
        PHDR: if (st.out_free) begin
          k <= k + 6'd1;
          if (k == BLK_LAST) state <= PIX;
        end
        PIX: if (st.out_free) begin
          k     <= '0;
          state <= st.rem_one ? TAIL : IDLE;
        end
        TAIL: if (st.out_free) begin
          k <= k + 6'd1;
          if (k == TAIL_LAST) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: sv/pngse_dp.sv
// ----------------------------------------------------------------------------
// PNG stored-block encoder datapath
// Geometry, IDAT length, counters, CRC-32, Adler-32 and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pngse_dp import pngse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic [7:0]  pixel_byte,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_image
);

  logic [13:0] image_width, image_height;
  logic        has_alpha;
  logic [13:0] geo_w, geo_h;
  logic        geo_a;
  logic [15:0] row_len;
  logic [28:0] raw_tot;
  logic [13:0] nblk;
  logic [31:0] idat_len;
  logic [7:0]  pix;
  logic        started;
  logic [15:0] byte_in_row, block_fill;
  logic [28:0] raw_remaining;
  logic [31:0] crc_reg;
  logic [15:0] adler_low, adler_high;

  logic [13:0] w_clamp, h_clamp;
  logic [16:0] r_sum, r_red;
  logic [12:0] q0;
  logic [7:0]  byte_sel;
  logic        crc_feed, crc_init;
  logic [31:0] crc_inv, adler_word;
  logic [15:0] blk_n, blk_ninv;
  logic [16:0] lo_s, hi_s;
  logic [15:0] lo_n, hi_n;
  logic        raw_emit, finish;

  assign w_clamp = (image_width == 14'd0) ? 14'd1 :
                   (image_width > 14'(MAX_W)) ? 14'(MAX_W) : image_width;
  assign h_clamp = (image_height == 14'd0) ? 14'd1 :
                   (image_height > 14'(MAX_H)) ? 14'(MAX_H) : image_height;

  assign q0    = raw_tot[28:16];
  assign r_sum = {4'd0, q0} + {1'b0, raw_tot[15:0]};
  assign r_red = (r_sum >= 17'(BLK_LIMIT)) ? r_sum - 17'(BLK_LIMIT) : r_sum;

  assign crc_inv    = ~crc_reg;
  assign adler_word = {adler_high, adler_low};
  assign blk_n      = (raw_remaining > 29'(BLK_LIMIT)) ? 16'(BLK_LIMIT) : raw_remaining[15:0];
  assign blk_ninv   = ~blk_n;

  always_comb begin
    byte_sel = 8'h00;
    crc_feed = 1'b0;
    crc_init = 1'b0;
    case (cmd.src)
      SRC_HDR: begin
        case (cmd.idx)
          6'd0:  byte_sel = 8'h89;
          6'd1:  byte_sel = 8'h50;
          6'd2:  byte_sel = 8'h4E;
          6'd3:  byte_sel = 8'h47;
          6'd4:  byte_sel = 8'h0D;
          6'd5:  byte_sel = 8'h0A;
          6'd6:  byte_sel = 8'h1A;
          6'd7:  byte_sel = 8'h0A;
          6'd11: byte_sel = 8'h0D;
          6'd12: byte_sel = 8'h49;
          6'd13: byte_sel = 8'h48;
          6'd14: byte_sel = 8'h44;
          6'd15: byte_sel = 8'h52;
          6'd18: byte_sel = {2'd0, geo_w[13:8]};
          6'd19: byte_sel = geo_w[7:0];
          6'd22: byte_sel = {2'd0, geo_h[13:8]};
          6'd23: byte_sel = geo_h[7:0];
          6'd24: byte_sel = 8'h08;
          6'd25: byte_sel = geo_a ? 8'h06 : 8'h02;
          6'd29: byte_sel = crc_inv[31:24];
          6'd30: byte_sel = crc_inv[23:16];
          6'd31: byte_sel = crc_inv[15:8];
          6'd32: byte_sel = crc_inv[7:0];
          6'd33: byte_sel = idat_len[31:24];
          6'd34: byte_sel = idat_len[23:16];
          6'd35: byte_sel = idat_len[15:8];
          6'd36: byte_sel = idat_len[7:0];
          6'd37: byte_sel = 8'h49;
          6'd38: byte_sel = 8'h44;
          6'd39: byte_sel = 8'h41;
          6'd40: byte_sel = 8'h54;
          6'd41: byte_sel = 8'h78;
          6'd42: byte_sel = 8'h01;
          default: byte_sel = 8'h00;
        endcase
        crc_feed = (cmd.idx >= 6'd12 && cmd.idx <= 6'd28) || (cmd.idx >= 6'd37);
        crc_init = (cmd.idx == 6'd12) || (cmd.idx == 6'd37);
      end
      SRC_BLK: begin
        crc_feed = 1'b1;
        case (cmd.idx)
          6'd0:    byte_sel = {7'd0, raw_remaining <= 29'(BLK_LIMIT)};
          6'd1:    byte_sel = blk_n[7:0];
          6'd2:    byte_sel = blk_n[15:8];
          6'd3:    byte_sel = blk_ninv[7:0];
          default: byte_sel = blk_ninv[15:8];
        endcase
      end
      SRC_FILT: crc_feed = 1'b1;
      SRC_PIX: begin
        byte_sel = pix;
        crc_feed = 1'b1;
      end
      SRC_TAIL: begin
        case (cmd.idx)
          6'd0:  byte_sel = adler_word[31:24];
          6'd1:  byte_sel = adler_word[23:16];
          6'd2:  byte_sel = adler_word[15:8];
          6'd3:  byte_sel = adler_word[7:0];
          6'd4:  byte_sel = crc_inv[31:24];
          6'd5:  byte_sel = crc_inv[23:16];
          6'd6:  byte_sel = crc_inv[15:8];
          6'd7:  byte_sel = crc_inv[7:0];
          6'd12: byte_sel = 8'h49;
          6'd13: byte_sel = 8'h45;
          6'd14: byte_sel = 8'h4E;
          6'd15: byte_sel = 8'h44;
          6'd16: byte_sel = crc_inv[31:24];
          6'd17: byte_sel = crc_inv[23:16];
          6'd18: byte_sel = crc_inv[15:8];
          6'd19: byte_sel = crc_inv[7:0];
          default: byte_sel = 8'h00;
        endcase
        crc_feed = (cmd.idx <= 6'd3) || (cmd.idx >= 6'd12 && cmd.idx <= 6'd15);
        crc_init = (cmd.idx == 6'd12);
      end
      default: ;
    endcase
  end

  assign lo_s = {1'b0, adler_low} + {9'd0, byte_sel};
  assign lo_n = (lo_s >= 17'(ADLER_MOD)) ? 16'(lo_s - 17'(ADLER_MOD)) : lo_s[15:0];
  assign hi_s = {1'b0, adler_high} + {1'b0, lo_n};
  assign hi_n = (hi_s >= 17'(ADLER_MOD)) ? 16'(hi_s - 17'(ADLER_MOD)) : hi_s[15:0];

  assign raw_emit = cmd.emit && (cmd.src == SRC_FILT || cmd.src == SRC_PIX);
  assign finish   = cmd.emit && cmd.eoi;

  assign st.started   = started;
  assign st.bir_zero  = (byte_in_row == 16'd0);
  assign st.fill_zero = (block_fill == 16'd0);
  assign st.rem_one   = (raw_remaining == 29'd1);
  assign st.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 14'd1;
      image_height  <= 14'd1;
      has_alpha     <= 1'b0;
      geo_w         <= 14'd1;
      geo_h         <= 14'd1;
      geo_a         <= 1'b0;
      started       <= 1'b0;
      byte_in_row   <= '0;
      block_fill    <= '0;
      raw_remaining <= '0;
      crc_reg       <= '1;
      adler_low     <= 16'd1;
      adler_high    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          REG_ALPHA:  has_alpha    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        geo_w      <= w_clamp;
        geo_h      <= h_clamp;
        geo_a      <= has_alpha;
        started    <= 1'b1;
        adler_low  <= 16'd1;
        adler_high <= '0;
      end
      if (cmd.emit && crc_feed) crc_reg <= crc_byte(crc_init ? '1 : crc_reg, byte_sel);
      if (cmd.emit && cmd.src == SRC_HDR && cmd.idx == HDR_LEN0) raw_remaining <= raw_tot;
      if (raw_emit) begin
        adler_low     <= lo_n;
        adler_high    <= hi_n;
        raw_remaining <= raw_remaining - 29'd1;
        block_fill    <= (block_fill == 16'(BLK_LIMIT - 1)) ? 16'd0 : block_fill + 16'd1;
      end
      if (cmd.emit && cmd.src == SRC_PIX)
        byte_in_row <= (byte_in_row + 16'd1 >= row_len) ? 16'd0 : byte_in_row + 16'd1;
      if (finish) begin
        started     <= 1'b0;
        byte_in_row <= '0;
        block_fill  <= '0;
      end
      if (cmd.emit)          out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) pix <= pixel_byte;
    row_len  <= geo_a ? {geo_w, 2'b00} : ({1'b0, geo_w, 1'b0} + {2'b00, geo_w});
    raw_tot  <= 29'(geo_h) * 29'({1'b0, row_len} + 17'd1);
    nblk     <= {1'b0, q0} + 14'(r_sum >= 17'(BLK_LIMIT)) + 14'(r_red != 17'd0);
    idat_len <= {3'd0, raw_tot} + {16'd0, nblk, 2'b00} + {18'd0, nblk} + 32'd6;
    if (cmd.emit) begin
      out_byte     <= byte_sel;
      last_of_run  <= cmd.last;
      end_of_image <= cmd.eoi;
    end
  end

  `ASSERT_ALWAYS(a_eoi_last, clk, rst, out_valid && end_of_image |-> last_of_run)
  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.emit && out_valid && out_stall)
  `ASSERT_ALWAYS(a_finish_clears, clk, rst, finish |=> !started && byte_in_row == 16'd0)

endmodule
